@@ hdl/mrf_pkg.sv @@
`default_nettype none
package mrf_pkg;

  localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam int          BODY_LEN        = 6;
  localparam int          FRAME_LEN       = 8;
  localparam int          IDX_W           = $clog2(FRAME_LEN);
  localparam int          FIFO_DEPTH_DEF  = 2;
  localparam int          IN_TDATA_W      = 48;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic [7:0]  device;
    logic [7:0]  func;
    logic [15:0] reg_addr;
    logic [15:0] reg_value;
  } body_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hdl/modbus_rtu_request_framer.sv @@
// Each request passes the queue, the body register and the output register.
// The byte-wide output channel sets the rate: one frame byte per cycle while
// out_tready allows it, with the CRC folded in one byte per cycle.
// A small request queue decouples input acceptance from frame serialization.
// Reset (rst_n low, synchronous) empties the queue and the output register.
`default_nettype none
module modbus_rtu_request_framer
  import mrf_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [0] opcode, [8:1] device_address, [24:9] register_address,
  // [40:25] register_value, [47:41] zero
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [7:0] frame_byte
  output logic [7:0]                 out_tdata,
  output logic                       out_tlast
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  fifo_stat_t    q_stat;
  body_t         q_wdata, q_rdata;
  logic          q_push, q_pop;
  logic [CW-1:0] q_fill;

  mrf_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  mrf_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat),
    .fill  (q_fill)
  );

  mrf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_fill <= CW'(FIFO_DEPTH))
    else $error("queue fill above depth");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (q_fill == CW'(FIFO_DEPTH)))
    else $error("input stalled with queue not full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> (q_fill == $past(q_fill) + CW'(1)))
    else $error("queue fill not tracking push");

endmodule
`default_nettype wire

@@ hdl/mrf_front.sv @@
`default_nettype none
module mrf_front
  import mrf_pkg::*;
(
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire fifo_stat_t            q_stat,
  output logic                       q_push,
  output body_t                      q_wdata
);

  logic        opcode;
  logic [7:0]  device_address;
  logic [15:0] register_address;
  logic [15:0] register_value;

  assign opcode           = in_tdata[0];
  assign device_address   = in_tdata[8:1];
  assign register_address = in_tdata[24:9];
  assign register_value   = in_tdata[40:25];

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && !q_stat.full;

  always_comb begin
    q_wdata.device    = device_address;
    q_wdata.func      = (opcode == OP_READ) ? FN_READ_HOLDING : FN_WRITE_SINGLE;
    q_wdata.reg_addr  = register_address;
    q_wdata.reg_value = register_value;
  end

endmodule
`default_nettype wire

@@ hdl/mrf_fifo.sv @@
`default_nettype none
module mrf_fifo
  import mrf_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire body_t                      wdata,
  input  wire logic                       pop,
  output body_t                           rdata,
  output fifo_stat_t                      stat,
  output logic [$clog2(DEPTH+1)-1:0]      fill
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  body_t         mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign fill       = cnt_r;
  assign rdata      = mem_r[rptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

@@ hdl/mrf_back.sv @@
`default_nettype none
module mrf_back
  import mrf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire fifo_stat_t q_stat,
  input  wire body_t      q_rdata,
  output logic            q_pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast
);

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  body_t            body_r, body_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       odata_r, odata_nxt;
  logic             olast_r, olast_nxt;
  logic             advance;
  logic             at_end;
  logic [7:0]       cur_byte;

  assign advance = busy_r && (!ovalid_r || out_tready);
  assign at_end  = (idx_r == IDX_W'(FRAME_LEN - 1));
  assign q_pop   = !q_stat.empty && (!busy_r || (advance && at_end));

  always_comb begin
    case (idx_r)
      3'd0:    cur_byte = body_r.device;
      3'd1:    cur_byte = body_r.func;
      3'd2:    cur_byte = body_r.reg_addr[15:8];
      3'd3:    cur_byte = body_r.reg_addr[7:0];
      3'd4:    cur_byte = body_r.reg_value[15:8];
      3'd5:    cur_byte = body_r.reg_value[7:0];
      3'd6:    cur_byte = crc_r[7:0];
      default: cur_byte = crc_r[15:8];
    endcase
  end

  always_comb begin
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    body_nxt   = body_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    if (advance) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = cur_byte;
      olast_nxt  = at_end;
      idx_nxt    = idx_r + IDX_W'(1);
      if (idx_r < IDX_W'(BODY_LEN)) begin
        crc_nxt = crc_byte(crc_r, cur_byte);
      end
      if (at_end) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      crc_nxt  = CRC_INIT;
      body_nxt = q_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r   <= crc_nxt;
    body_r  <= body_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

@@ dv/modbus_rtu_request_framer_tb.sv @@
`default_nettype none
module modbus_rtu_request_framer_tb;
  import mrf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    logic        opcode;
    logic [7:0]  device;
    logic [15:0] reg_addr;
    logic [15:0] reg_value;
  } request_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;
  logic                  out_tlast;

  frame_beat_t frame_beats_q[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          mismatches;
  int          quiet_cycles;

  modbus_rtu_request_framer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // CRC-16/MODBUS, reflected, LSB first
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  task automatic predict_frame(input request_t r);
    logic [7:0]  body [BODY_LEN];
    logic [15:0] crc;
    frame_beat_t beat;
    body[0] = r.device;
    body[1] = (r.opcode == OP_READ) ? FN_READ_HOLDING : FN_WRITE_SINGLE;
    body[2] = r.reg_addr[15:8];
    body[3] = r.reg_addr[7:0];
    body[4] = r.reg_value[15:8];
    body[5] = r.reg_value[7:0];
    crc = CRC_INIT;
    for (int k = 0; k < BODY_LEN; k++) begin
      crc = crc16_fold(crc, body[k]);
      beat.data = body[k];
      beat.last = 1'b0;
      frame_beats_q.push_back(beat);
    end
    beat.data = crc[7:0];
    beat.last = 1'b0;
    frame_beats_q.push_back(beat);
    beat.data = crc[15:8];
    beat.last = 1'b1;
    frame_beats_q.push_back(beat);
  endtask

  task automatic send_request(input request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, r.reg_value, r.reg_addr, r.device, r.opcode};
    do @(posedge clk); while (!in_tready);
    predict_frame(r);
  endtask

  function automatic request_t make_request(input logic op, input logic [7:0] dev,
                                            input logic [15:0] addr, input logic [15:0] val);
    request_t r;
    r.opcode    = op;
    r.device    = dev;
    r.reg_addr  = addr;
    r.reg_value = val;
    return r;
  endfunction

  function automatic request_t random_request();
    return make_request(1'($urandom_range(1)), 8'($urandom_range(255)),
                        16'($urandom_range(65535)), 16'($urandom_range(65535)));
  endfunction

  task automatic wait_frames_drained();
    while (frame_beats_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(make_request(OP_WRITE, 8'h00, 16'h0000, 16'h0000));
    send_request(make_request(OP_READ,  8'hFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(OP_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(OP_READ,  8'h00, 16'h0000, 16'h0000));
    send_request(make_request(OP_WRITE, 8'h55, 16'hAAAA, 16'h5555));
    send_request(make_request(OP_READ,  8'hAA, 16'h5555, 16'hAAAA));
    send_request(make_request(OP_WRITE, 8'h01, 16'h0001, 16'h0001));
    send_request(make_request(OP_READ,  8'h80, 16'h8000, 16'h8000));
    // read with zero count and with an oversized count
    send_request(make_request(OP_READ,  8'h11, 16'h006B, 16'h0000));
    send_request(make_request(OP_READ,  8'h11, 16'h006B, 16'hFFFF));
    send_request(make_request(OP_READ,  8'h01, 16'h0000, 16'h000A));
    send_request(make_request(OP_WRITE, 8'h11, 16'h0001, 16'h0003));
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      send_request(random_request());
    end
  endtask

  task automatic test_drain_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    for (int i = 0; i < 6; i++) begin
      send_request(random_request());
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait_frames_drained();
    for (int i = 0; i < 6; i++) begin
      send_request(random_request());
    end
  endtask

  // result checker and receiver backpressure
  always @(posedge clk) begin
    frame_beat_t exp_beat;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_beats_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected frame byte %h last %b", out_tdata, out_tlast);
        end
      end else begin
        exp_beat = frame_beats_q.pop_front();
        if (out_tdata !== exp_beat.data || out_tlast !== exp_beat.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("frame byte mismatch: expected %h last %b, got %h last %b",
                     exp_beat.data, exp_beat.last, out_tdata, out_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("modbus_rtu_request_framer_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_random_phase(0, 0, 25);
    test_random_phase(59, 0, 25);
    test_random_phase(0, 59, 25);
    test_random_phase(27, 27, 25);
    test_drain_pause();
    test_random_phase(0, 0, 10);

    in_tvalid <= 1'b0;
    @(posedge clk);
    wait_frames_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && frame_beats_q.size() == 0) begin
      $display("modbus_rtu_request_framer_tb passed");
    end else begin
      $display("modbus_rtu_request_framer_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
hdl/mrf_pkg.sv
hdl/mrf_front.sv
hdl/mrf_fifo.sv
hdl/mrf_back.sv
hdl/modbus_rtu_request_framer.sv
dv/modbus_rtu_request_framer_tb.sv
